// ===== rtl/core/gcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// gcpd_pkg
// Types, command codes and helpers shared by the GPU control port decoder.
// ----------------------------------------------------------------------------
package gcpd_pkg;

	localparam int COUNT_WIDTH = 32;

	localparam logic [31:0] STATUS_RESET_DEFAULT = 32'h1480_2000;
	localparam logic [31:0] STATUS_MODE_MASK     = 32'h007f_0000;

	localparam int ST_DMAREQ_BIT = 25;
	localparam int ST_IRQ_BIT    = 24;
	localparam int ST_DISP_BIT   = 23;

	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

	// bus access kinds
	localparam logic [1:0] ACT_DATA      = 2'd0;
	localparam logic [1:0] ACT_CTRL      = 2'd1;
	localparam logic [1:0] ACT_STATUS    = 2'd2;
	localparam logic [1:0] ACT_UNDEFINED = 2'd3;

	// control commands, top byte of the control word
	localparam logic [7:0] CMD_FULL_RESET = 8'h00;
	localparam logic [7:0] CMD_BUF_RESET  = 8'h01;
	localparam logic [7:0] CMD_IRQ_ACK    = 8'h02;
	localparam logic [7:0] CMD_DISP_EN    = 8'h03;
	localparam logic [7:0] CMD_DMA_DIR    = 8'h04;
	localparam logic [7:0] CMD_ORIGIN     = 8'h05;
	localparam logic [7:0] CMD_DISP_MODE  = 8'h08;

	// DMA directions, low bits of the DMA direction command
	localparam logic [1:0] DMA_DIR_OFF    = 2'd0;
	localparam logic [1:0] DMA_DIR_TO_GPU = 2'd2;

	// configuration register indexes
	localparam logic REG_STATUS_RESET = 1'b0;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] data_word;
	} access_t;

	typedef struct packed {
		logic [31:0] status_word;
		logic        display_on;
		logic [9:0]  origin_x;
		logic [8:0]  origin_y;
		logic [9:0]  screen_width;
		logic [8:0]  screen_height;
		logic        interlace_on;
		logic        deep_color;
		logic [31:0] buffer_epoch;
		logic [31:0] data_word_count;
		logic [31:0] control_word_count;
	} result_t;

	typedef struct packed {
		logic [31:0]            status;
		logic                   disp_enable;
		logic [9:0]             disp_x;
		logic [8:0]             disp_y;
		logic [9:0]             disp_width;
		logic [8:0]             disp_height;
		logic                   disp_interlace;
		logic                   disp_rgb24;
		logic [COUNT_WIDTH-1:0] epoch_cnt;
		logic [COUNT_WIDTH-1:0] data_cnt;
		logic [COUNT_WIDTH-1:0] ctrl_cnt;
	} gpu_state_t;

	localparam gpu_state_t STATE_RESET = '{status: STATUS_RESET_DEFAULT, default: '0};

	function automatic logic [9:0] hres(input logic [1:0] sel);
		logic [9:0] w;
		case (sel)
			2'd0:    w = 10'd256;
			2'd1:    w = 10'd320;
			2'd2:    w = 10'd512;
			default: w = 10'd640;
		endcase
		return w;
	endfunction

	// low 32 bits of a counter, zero-extended when the counter is narrower
	function automatic logic [31:0] count_out(input logic [COUNT_WIDTH-1:0] cnt);
		logic [COUNT_WIDTH+31:0] ext;
		ext = {32'd0, cnt};
		return ext[31:0];
	endfunction

endpackage

// ===== rtl/core/gpu_control_port_decoder.sv =====
// ----------------------------------------------------------------------------
// gpu_control_port_decoder
// GPU control port: counts command data writes, decodes control writes and
// reports status, display state and counters after every bus access.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  access    in         access_valid/access_ready access_t (action, data_word)
//  result    out        result_valid/result_ready result_t (status and display)
//  config    in         APB psel/penable/pwrite   status reset value at 0x0
//
//  One transfer per cycle sustained while results are taken; each access
//  is registered first in the input stage, then in the result register.
//  The input stage keeps taking accesses while a result waits, and holds
//  only when both it and the result register are full and result_ready is low.
//  Reset loads the status register and the config register with 0x14802000
//  and clears display state and counters.
//
module gpu_control_port_decoder import gcpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        access_valid,
	output logic        access_ready,
	input  access_t     access,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        valid_s1;
	access_t     acc_s1;
	gpu_state_t  state_q;
	gpu_state_t  state_nxt;
	logic        res_valid_q;
	result_t     res_q;
	logic [31:0] status_rst_q;
	logic        advance;
	logic        fire;
	logic        reg_idx;

	// Advance the input stage whenever the result register is free or drains.
	assign advance      = !res_valid_q || result_ready;
	assign access_ready = !valid_s1 || advance;
	assign fire         = valid_s1 && advance;

	// Configuration port: no wait states, one register.
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign prdata  = (reg_idx == REG_STATUS_RESET) ? status_rst_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_rst_q <= STATUS_RESET_DEFAULT;
		end else if (psel && penable && pwrite && pready && reg_idx == REG_STATUS_RESET) begin
			status_rst_q <= pwdata;
		end
	end

	// Input stage: capture each access transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (access_ready) begin
			valid_s1 <= access_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (access_ready && access_valid) begin
			acc_s1 <= access;
		end
	end

	gcpd_update u_update (
		.cur        (state_q),
		.acc        (acc_s1),
		.status_rst (status_rst_q),
		.nxt        (state_nxt)
	);

	// Commit the state change and the result together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.status_word        <= state_nxt.status;
			res_q.display_on         <= state_nxt.disp_enable;
			res_q.origin_x           <= state_nxt.disp_x;
			res_q.origin_y           <= state_nxt.disp_y;
			res_q.screen_width       <= state_nxt.disp_width;
			res_q.screen_height      <= state_nxt.disp_height;
			res_q.interlace_on       <= state_nxt.disp_interlace;
			res_q.deep_color         <= state_nxt.disp_rgb24;
			res_q.buffer_epoch       <= count_out(state_nxt.epoch_cnt);
			res_q.data_word_count    <= count_out(state_nxt.data_cnt);
			res_q.control_word_count <= count_out(state_nxt.ctrl_cnt);
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!access_ready |-> (valid_s1 && res_valid_q))
		else $error("access stalled with a free stage");

	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && acc_s1.action == ACT_DATA) |=>
		(state_q.data_cnt == $past(state_q.data_cnt) + CNT_ONE))
		else $error("data word not counted");

	a_ctrl_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && acc_s1.action == ACT_CTRL) |=>
		(state_q.ctrl_cnt == $past(state_q.ctrl_cnt) + CNT_ONE))
		else $error("control word not counted");

	a_read_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (acc_s1.action == ACT_STATUS || acc_s1.action == ACT_UNDEFINED))
		|=> $stable(state_q))
		else $error("status read changed state");

	a_result_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status_word == state_q.status))
		else $error("result status differs from state");
`endif

endmodule

// ===== rtl/core/gcpd_update.sv =====
// ----------------------------------------------------------------------------
// gcpd_update
// Next-state logic for one bus access: counters and control command decode.
// ----------------------------------------------------------------------------
module gcpd_update import gcpd_pkg::*; (
	input  gpu_state_t  cur,
	input  access_t     acc,
	input  logic [31:0] status_rst,
	output gpu_state_t  nxt
);

	logic [7:0]  cmd;
	logic [31:0] w;
	logic [1:0]  dir;
	logic        req;

	assign w   = acc.data_word;
	assign cmd = w[31:24];
	assign dir = w[1:0];

	always_comb begin
		nxt = cur;
		req = 1'b0;
		case (acc.action)
			ACT_DATA: begin
				nxt.data_cnt = cur.data_cnt + CNT_ONE;
			end
			ACT_CTRL: begin
				nxt.ctrl_cnt = cur.ctrl_cnt + CNT_ONE;
				case (cmd)
					CMD_FULL_RESET: begin
						nxt.status         = status_rst;
						nxt.disp_enable    = 1'b0;
						nxt.disp_x         = '0;
						nxt.disp_y         = '0;
						nxt.disp_width     = '0;
						nxt.disp_height    = '0;
						nxt.disp_interlace = 1'b0;
						nxt.disp_rgb24     = 1'b0;
						nxt.epoch_cnt      = cur.epoch_cnt + CNT_ONE;
					end
					CMD_BUF_RESET: begin
						nxt.epoch_cnt = cur.epoch_cnt + CNT_ONE;
					end
					CMD_IRQ_ACK: begin
						nxt.status[ST_IRQ_BIT] = 1'b0;
					end
					CMD_DISP_EN: begin
						nxt.status[ST_DISP_BIT] = w[0];
						nxt.disp_enable         = ~w[0];
					end
					CMD_DMA_DIR: begin
						// request line follows bit 28 for CPU-to-GPU, bit 27 for other directions, low when off
						if (dir == DMA_DIR_TO_GPU) begin
							req = cur.status[28];
						end else if (dir != DMA_DIR_OFF) begin
							req = cur.status[27];
						end
						nxt.status[30:29]         = dir;
						nxt.status[ST_DMAREQ_BIT] = req;
					end
					CMD_ORIGIN: begin
						nxt.disp_x = w[9:0];
						nxt.disp_y = w[18:10];
					end
					CMD_DISP_MODE: begin
						nxt.disp_width     = w[6] ? 10'd368 : hres(w[1:0]);
						nxt.disp_interlace = w[5];
						nxt.disp_height    = (w[2] && w[5]) ? 9'd480 : 9'd240;
						nxt.disp_rgb24     = w[4];
						nxt.status         = (cur.status & ~STATUS_MODE_MASK)
						                   | {9'd0, w[5:0], w[6], 16'd0};
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

endmodule
